// ----- hw/rtl/iset_pkg.sv -----
`default_nettype none

package iset_pkg;

  localparam int unsigned DEF_CACHE_GROUPS = 64;
  localparam int unsigned DEF_CAPACITY     = 256;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 9;

  // slot hash multiplier
  localparam logic [VALUE_W-1:0] HASH_MULT = 32'd2654435761;

  // store cells examined per search step
  localparam int unsigned GROUP_CELLS = 8;
  localparam int unsigned GROUP_SHIFT = 3;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_ERASE  = 2'd2
  } req_code_t;

  typedef enum logic [1:0] {
    ST_UNKNOWN = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2
  } cstat_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_CHECK,
    S_WAVE
  } state_t;

  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [VALUE_W-1:0] value;
  } iset_req_t;

  typedef struct packed {
    logic               found;
    logic               dropped;
    logic [COUNT_W-1:0] element_count;
  } iset_rsp_t;

  typedef struct packed {
    logic [VALUE_W-1:0] key;
    cstat_t             status;
  } cache_entry_t;

  typedef struct packed {
    logic push;
    logic shift;
    logic cmp;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/iset_ram.sv -----
`default_nettype none

module iset_ram #(
  parameter int unsigned WIDTH = iset_pkg::VALUE_W,
  parameter int unsigned DEPTH = 4 * iset_pkg::DEF_CACHE_GROUPS,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/iset_hash.sv -----
`default_nettype none

module iset_hash #(
  parameter int unsigned SLOTS = 4 * iset_pkg::DEF_CACHE_GROUPS,
  localparam int unsigned SW = $clog2(SLOTS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [iset_pkg::VALUE_W-1:0] value,
  output logic                         done,
  output logic [SW-1:0]                slot
);

  import iset_pkg::*;

  localparam bit POW2 = ((SLOTS & (SLOTS - 1)) == 0);

  if (POW2) begin : g_mask
    // only the low bits of the product survive the modulo
    localparam logic [SW-1:0] KLOW = SW'(HASH_MULT);

    always_ff @(posedge clk) begin
      if (rst) begin
        done <= 1'b0;
      end else begin
        done <= start;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        slot <= KLOW * value[SW-1:0];
      end
    end
  end else begin : g_serial
    // Horner over the value bits, msb first: acc = (2*acc + bit*K) mod SLOTS
    localparam int unsigned KMOD = HASH_MULT % SLOTS;
    localparam int unsigned BW   = $clog2(VALUE_W);

    logic [SW-1:0]      acc;
    logic [VALUE_W-1:0] sh;
    logic [BW-1:0]      cnt;
    logic               run;
    logic [SW:0]        dbl;
    logic [SW:0]        dbl_red;
    logic [SW:0]        add;
    logic [SW:0]        add_red;

    always_comb begin
      dbl     = {acc, 1'b0};
      dbl_red = (dbl >= (SW+1)'(SLOTS)) ? dbl - (SW+1)'(SLOTS) : dbl;
      add     = sh[VALUE_W-1] ? dbl_red + (SW+1)'(KMOD) : dbl_red;
      add_red = (add >= (SW+1)'(SLOTS)) ? add - (SW+1)'(SLOTS) : add;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        run  <= 1'b0;
        done <= 1'b0;
        cnt  <= '0;
      end else begin
        done <= 1'b0;
        if (start) begin
          run <= 1'b1;
          cnt <= '0;
        end else if (run) begin
          cnt <= cnt + 1'b1;
          if (cnt == BW'(VALUE_W - 1)) begin
            run  <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        acc <= '0;
        sh  <= value;
      end else if (run) begin
        acc <= add_red[SW-1:0];
        sh  <= {sh[VALUE_W-2:0], 1'b0};
      end
    end

    assign slot = acc;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/iset_cell.sv -----
`default_nettype none

module iset_cell (
  input  logic                                clk,
  input  iset_pkg::cell_ctrl_t                ctrl,
  input  logic signed [iset_pkg::VALUE_W-1:0] key,
  input  logic signed [iset_pkg::VALUE_W-1:0] left_val,
  input  logic signed [iset_pkg::VALUE_W-1:0] right_val,
  input  logic                                del_in,
  output logic signed [iset_pkg::VALUE_W-1:0] val,
  output logic                                del_out,
  output logic                                match
);

  import iset_pkg::*;

  always_comb begin
    match   = ctrl.cmp && (val == key);
    // set from the first matching cell onwards
    del_out = del_in || match;
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      val <= left_val;
    end else if (ctrl.shift && del_out) begin
      val <= right_val;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/integer_set_with_lookup_cache_top.sv -----
// Sequence: a cache hit, an insert, a dropped insert or an unused code gives its result strobe
//   from the check state after the hash; an erase not cached absent or a lookup that misses the
//   cache searches the store in groups of 8 stored cells, at least one group, and a lookup stops
//   at the group holding its first match. With 4*CACHE_GROUPS not a power of two the slot
//   hash runs bit-serially over the value bits.
// Throughput: one transaction at a time; the next start is taken in the strobe cycle.
// Reset: a pass clears the 4*CACHE_GROUPS cache slots, one a cycle, with busy held high.
`default_nettype none

module integer_set_with_lookup_cache_top #(
  parameter int unsigned CACHE_GROUPS = iset_pkg::DEF_CACHE_GROUPS,
  parameter int unsigned CAPACITY     = iset_pkg::DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  iset_pkg::iset_req_t request,
  output iset_pkg::iset_rsp_t result,
  output logic                strobe
);

  import iset_pkg::*;

  localparam int unsigned SLOTS = 4 * CACHE_GROUPS;
  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned NSEG  = (CAPACITY + GROUP_CELLS - 1) / GROUP_CELLS;
  localparam int unsigned SEGW  = (NSEG > 1) ? $clog2(NSEG) : 1;
  localparam int unsigned EW    = (SEGW + GROUP_SHIFT + 1 > CW) ? SEGW + GROUP_SHIFT + 1 : CW;

  state_t          state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [SEGW-1:0] wave_seg, wave_seg_next;
  logic            del_flag, del_flag_next;
  logic [SW-1:0]   clr_addr, clr_addr_next;
  iset_rsp_t       result_next;
  logic            strobe_next;
  iset_req_t       held;

  logic            hash_start;
  logic            hash_done;
  logic [SW-1:0]   slot;

  logic                              cw_en;
  logic [SW-1:0]                     cw_addr;
  cache_entry_t                      cw_data;
  logic [$bits(cache_entry_t)-1:0]   cache_rdata;
  cache_entry_t                      entry;

  logic            keyhit;
  logic            hit_present;
  logic            hit_absent;
  logic            full;
  logic            any_match;
  logic            flag_new;
  logic [EW-1:0]   seg_next_start;
  logic            wave_done;
  logic            push_en;

  logic signed [VALUE_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]       match_vec;
  logic [CAPACITY-1:0]       del_in;
  logic [CAPACITY-1:0]       del_out;
  cell_ctrl_t                ctrl [CAPACITY];

  assign busy       = (state != S_IDLE);
  assign hash_start = (state == S_IDLE) && start;

  iset_hash #(
    .SLOTS(SLOTS)
  ) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .value (request.value),
    .done  (hash_done),
    .slot  (slot)
  );

  iset_ram #(
    .WIDTH($bits(cache_entry_t)),
    .DEPTH(SLOTS)
  ) u_cache (
    .clk   (clk),
    .we    (cw_en),
    .waddr (cw_addr),
    .wdata (cw_data),
    .raddr (slot),
    .rdata (cache_rdata)
  );

  assign entry = cache_entry_t'(cache_rdata);

  // store: row of cells, search sweeps one group per cycle
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int unsigned SEG = i / GROUP_CELLS;
    logic                      active;
    logic signed [VALUE_W-1:0] left_val;
    logic signed [VALUE_W-1:0] right_val;

    always_comb begin
      active         = (state == S_WAVE) && (wave_seg == SEGW'(SEG));
      ctrl[i].push   = push_en;
      ctrl[i].shift  = active && (held.req_type == REQ_ERASE);
      ctrl[i].cmp    = active && (CW'(i) < count);
    end

    if (i % GROUP_CELLS == 0) begin : g_head
      assign del_in[i] = del_flag;
    end else begin : g_body
      assign del_in[i] = del_out[i-1];
    end

    if (i == 0) begin : g_first
      assign left_val = held.value;
    end else begin : g_left
      assign left_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_right
      assign right_val = cell_val[i+1];
    end

    iset_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[i]),
      .key       (held.value),
      .left_val  (left_val),
      .right_val (right_val),
      .del_in    (del_in[i]),
      .val       (cell_val[i]),
      .del_out   (del_out[i]),
      .match     (match_vec[i])
    );
  end

  always_comb begin
    keyhit         = (entry.key == held.value);
    hit_present    = keyhit && (entry.status == ST_PRESENT);
    hit_absent     = keyhit && (entry.status == ST_ABSENT);
    full           = (count >= CW'(CAPACITY));
    any_match      = |match_vec;
    flag_new       = del_flag || any_match;
    seg_next_start = (EW'(wave_seg) + EW'(1)) << GROUP_SHIFT;
    wave_done      = (seg_next_start >= EW'(count)) ||
                     ((held.req_type == REQ_LOOKUP) && flag_new);
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    wave_seg_next  = wave_seg;
    del_flag_next  = del_flag;
    clr_addr_next  = clr_addr;
    result_next    = result;
    strobe_next    = 1'b0;
    push_en        = 1'b0;
    cw_en          = 1'b0;
    cw_addr        = slot;
    cw_data.key    = held.value;
    cw_data.status = ST_UNKNOWN;

    case (state)
      S_CLEAR: begin
        cw_en         = 1'b1;
        cw_addr       = clr_addr;
        cw_data       = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == SW'(SLOTS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        result_next.found         = 1'b0;
        result_next.dropped       = 1'b0;
        result_next.element_count = COUNT_W'(count);
        wave_seg_next             = '0;
        del_flag_next             = 1'b0;
        state_next                = S_IDLE;
        strobe_next               = 1'b1;
        case (held.req_type)
          REQ_LOOKUP: begin
            if (hit_present) begin
              result_next.found = 1'b1;
            end else if (!hit_absent) begin
              state_next  = S_WAVE;
              strobe_next = 1'b0;
            end
          end
          REQ_INSERT: begin
            if (!hit_present) begin
              if (full) begin
                result_next.dropped = 1'b1;
              end else begin
                cw_en                     = 1'b1;
                cw_data.status            = ST_PRESENT;
                push_en                   = 1'b1;
                count_next                = count + 1'b1;
                result_next.element_count = COUNT_W'(count + 1'b1);
              end
            end
          end
          REQ_ERASE: begin
            if (!hit_absent) begin
              cw_en          = 1'b1;
              cw_data.status = ST_ABSENT;
              state_next     = S_WAVE;
              strobe_next    = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      S_WAVE: begin
        del_flag_next = flag_new;
        wave_seg_next = wave_seg + 1'b1;
        if (wave_done) begin
          state_next  = S_IDLE;
          strobe_next = 1'b1;
          if (held.req_type == REQ_LOOKUP) begin
            cw_en             = 1'b1;
            cw_data.status    = flag_new ? ST_PRESENT : ST_ABSENT;
            result_next.found = flag_new;
          end else if (flag_new) begin
            count_next                = count - 1'b1;
            result_next.element_count = COUNT_W'(count - 1'b1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      count    <= '0;
      wave_seg <= '0;
      del_flag <= 1'b0;
      clr_addr <= '0;
      strobe   <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      wave_seg <= wave_seg_next;
      del_flag <= del_flag_next;
      clr_addr <= clr_addr_next;
      strobe   <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (hash_start) begin
      held <= request;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/iset_checker.sv -----
`default_nettype none

module iset_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input iset_pkg::iset_rsp_t result,
  input logic                strobe
);

  import iset_pkg::*;

  // a result is only given once the block is free again
  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  a_strobe_pulse: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("result strobe longer than one cycle");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !(result.found && result.dropped))
    else $error("found and dropped both set");

endmodule

bind integer_set_with_lookup_cache_top iset_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .result (result),
  .strobe (strobe)
);

`default_nettype wire
